### sv/frc_pkg.sv
package frc_pkg;

    localparam int MAX_DIM_DEF     = 4096;
    localparam int TRIG_STAGES_DEF = 16;

    localparam int N_LANES = 6;   // vstart, vend, hstart, hend, phi, theta
    localparam int ANG_W   = 18;  // Q2.16 angle
    localparam int QUO_W   = 18;  // quotient bits of every long division
    localparam int X_W     = 19;  // CORDIC x / y
    localparam int Z_W     = 20;  // CORDIC residual angle
    localparam int SC_W    = 18;  // clamped sine / cosine, Q1.16
    localparam int ZS_W    = 18;  // zscale after the lower clamp
    localparam int D_W     = 21;  // zscale - numerator
    localparam int OUT_W   = 17;
    localparam int CFG_W   = 13;
    localparam int FOV_W   = 8;
    localparam int COORD_W = 12;

    localparam logic [16:0] PI_Q32_LO = 17'(64'd13493037705);
    localparam logic [16:0] PI_Q32_HI = 17'(64'd13493037705 >> 17);

    localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [X_W-1:0] CORDIC_GAIN = 19'sd39797;
    localparam logic signed [SC_W-1:0] ONE_Q16    = 18'sd65536;
    localparam logic signed [OUT_W-1:0] OUT_MAX   = 17'sd65535;
    localparam logic signed [OUT_W-1:0] OUT_MIN   = -17'sd65536;

    typedef enum logic [2:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_HFOV       = 3'd4,
        CFG_VFOV       = 3'd5
    } t_cfg_idx;

    function automatic logic signed [Z_W-1:0] atan_q16(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:       v = 20'sd51472;
            1:       v = 20'sd30386;
            2:       v = 20'sd16055;
            3:       v = 20'sd8150;
            4:       v = 20'sd4091;
            5:       v = 20'sd2047;
            6:       v = 20'sd1024;
            7:       v = 20'sd512;
            8:       v = 20'sd256;
            9:       v = 20'sd128;
            10:      v = 20'sd64;
            11:      v = 20'sd32;
            12:      v = 20'sd16;
            13:      v = 20'sd8;
            14:      v = 20'sd4;
            15:      v = 20'sd2;
            16:      v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

    // clamp to [-1.0, 1.0] in Q1.16
    function automatic logic signed [SC_W-1:0] sat_unit(input logic signed [X_W:0] v);
        logic signed [SC_W-1:0] r;
        if (v > (X_W+1)'(ONE_Q16)) begin
            r = ONE_Q16;
        end else if (v < -(X_W+1)'(ONE_Q16)) begin
            r = -ONE_Q16;
        end else begin
            r = SC_W'(v);
        end
        return r;
    endfunction

endpackage

### sv/frc_div_cell.sv
// One restoring long-division step over L lanes; sideband tag rides along.
module frc_div_cell import frc_pkg::*; #(
    parameter int L  = 1,
    parameter int DW = 18,
    parameter int LW = 18,
    parameter int QW = 18,
    parameter int TW = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [TW-1:0]          i_tag,
    input  logic [L-1:0][DW-1:0]   i_rem,
    input  logic [L-1:0][LW-1:0]   i_low,
    input  logic [L-1:0][QW-1:0]   i_quo,
    input  logic [L-1:0][DW-1:0]   i_div,
    output logic                   o_vld,
    output logic [TW-1:0]          o_tag,
    output logic [L-1:0][DW-1:0]   o_rem,
    output logic [L-1:0][LW-1:0]   o_low,
    output logic [L-1:0][QW-1:0]   o_quo,
    output logic [L-1:0][DW-1:0]   o_div
);

    logic                 r_vld;
    logic [TW-1:0]        r_tag;
    logic [L-1:0][DW-1:0] r_rem, n_rem, r_div;
    logic [L-1:0][LW-1:0] r_low, n_low;
    logic [L-1:0][QW-1:0] r_quo, n_quo;

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        for (int k = 0; k < L; k++) begin
            t = {i_rem[k], i_low[k][LW-1]};
            ge = (t >= {1'b0, i_div[k]});
            n_rem[k] = ge ? DW'(t - {1'b0, i_div[k]}) : DW'(t);
            n_low[k] = {i_low[k][LW-2:0], 1'b0};
            n_quo[k] = {i_quo[k][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            r_rem <= n_rem;
            r_low <= n_low;
            r_quo <= n_quo;
            r_div <= i_div;
        end
    end

    assign o_vld = r_vld;
    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_low = r_low;
    assign o_quo = r_quo;
    assign o_div = r_div;

endmodule

### sv/frc_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation over L lanes.
module frc_cordic_cell import frc_pkg::*; #(
    parameter int STAGE = 0,
    parameter int L     = N_LANES
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_vld,
    input  logic [L-1:0][X_W-1:0]  i_x,
    input  logic [L-1:0][X_W-1:0]  i_y,
    input  logic [L-1:0][Z_W-1:0]  i_z,
    output logic                   o_vld,
    output logic [L-1:0][X_W-1:0]  o_x,
    output logic [L-1:0][X_W-1:0]  o_y,
    output logic [L-1:0][Z_W-1:0]  o_z
);

    localparam logic signed [Z_W-1:0] ATAN = atan_q16(STAGE);

    logic                 r_vld;
    logic [L-1:0][X_W-1:0] r_x, n_x, r_y, n_y;
    logic [L-1:0][Z_W-1:0] r_z, n_z;

    always_comb begin
        logic signed [X_W-1:0] x, y, dx, dy;
        logic signed [Z_W-1:0] z;
        for (int k = 0; k < L; k++) begin
            x  = $signed(i_x[k]);
            y  = $signed(i_y[k]);
            z  = $signed(i_z[k]);
            dx = y >>> STAGE;
            dy = x >>> STAGE;
            if (!z[Z_W-1]) begin
                n_x[k] = x - dx;
                n_y[k] = y + dy;
                n_z[k] = z - ATAN;
            end else begin
                n_x[k] = x + dx;
                n_y[k] = y - dy;
                n_z[k] = z + ATAN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_vld = r_vld;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

### sv/fisheye_remap_coordinate_generator.sv
// Channel   | Dir | Signals                                   | Contents
// s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready/tdata[24] | dst_col, dst_row
// m_axis    | out | o_m_axis_tvalid/i_m_axis_tready/tdata[40] | src_x_q4, src_y_q4, clipped
// cfg       | in  | i_cfg_we, i_cfg_idx[3], i_cfg_data[13]     | size and fov registers
//
// One request per clock while the output is not stalled. In order: stages A to D,
// the 18-step angle division chain, the CORDIC chain, P1 to P5, the 18-step map
// division chain and the output register. Every cell holds one step of one request and hands it on.
// Reset (synchronous, active low) clears all valid bits and loads the register
// defaults. A stalled output freezes the whole chain; the input is ready
// whenever the output register is empty or being drained.
module fisheye_remap_coordinate_generator import frc_pkg::*; #(
    parameter int MAX_DIM     = MAX_DIM_DEF,
    parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [11:0] dst_col, [23:12] dst_row
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [16:0] src_x_q4, [33:17] src_y_q4,
                                          // [34] clipped, [39:35] zero
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int DEN_W = $clog2(360 * MAX_DIM + 1);
    localparam int AD_W  = DEN_W + 16;   // angle divisor den << 16
    localparam int NW    = DEN_W + 35;   // angle dividend
    localparam int PW    = DIM_W + 26;   // map numerator

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic [FOV_W-1:0] r_hfov, r_vfov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= CFG_W'(1024);
            r_src_h <= CFG_W'(1024);
            r_dst_w <= CFG_W'(1024);
            r_dst_h <= CFG_W'(1024);
            r_hfov  <= FOV_W'(180);
            r_vfov  <= FOV_W'(180);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_w <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_h <= i_cfg_data;
                CFG_HFOV:       r_hfov  <= i_cfg_data[FOV_W-1:0];
                CFG_VFOV:       r_vfov  <= i_cfg_data[FOV_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (32'(d) > MAX_DIM) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = DIM_W'(d);
        end
        return r;
    endfunction

    function automatic logic [FOV_W-1:0] eff_fov(input logic [FOV_W-1:0] f);
        logic [FOV_W-1:0] r;
        if (f == '0) begin
            r = FOV_W'(1);
        end else if (f > FOV_W'(180)) begin
            r = FOV_W'(180);
        end else begin
            r = f;
        end
        return r;
    endfunction

    // The user must change the registers only while no request is in flight (the block
    // itself does not enforce this), so every stage reads them live.
    logic [DIM_W-1:0] w_ws, w_hs, w_wd, w_hd;
    logic [FOV_W-1:0] w_hf, w_vf;
    assign w_ws = eff_dim(r_src_w);
    assign w_hs = eff_dim(r_src_h);
    assign w_wd = eff_dim(r_dst_w);
    assign w_hd = eff_dim(r_dst_h);
    assign w_hf = eff_fov(r_hfov);
    assign w_vf = eff_fov(r_vfov);

    // ---------------- global advance ----------------
    logic r_out_vld;
    logic w_en;
    assign w_en            = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---------------- stage A: capture ----------------
    logic               r_a_vld;
    logic [COORD_W-1:0] r_a_col, r_a_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_col <= i_s_axis_tdata[11:0];
            r_a_row <= i_s_axis_tdata[23:12];
        end
    end

    // ---------------- stage B: angle fractions num/den ----------------
    logic                        r_b_vld;
    logic [N_LANES-1:0][DEN_W-1:0] r_b_num, n_b_num, r_b_den, n_b_den;

    always_comb begin
        logic [DIM_W-1:0] col, row;
        logic [DEN_W-1:0] c360;
        col  = (32'(r_a_col) >= 32'(w_wd)) ? DIM_W'(w_wd - 1'b1) : DIM_W'(r_a_col);
        row  = (32'(r_a_row) >= 32'(w_hd)) ? DIM_W'(w_hd - 1'b1) : DIM_W'(r_a_row);
        c360 = DEN_W'(360);
        n_b_num[0] = DEN_W'(9'd180 - 9'(w_vf));
        n_b_num[1] = DEN_W'(9'd180 + 9'(w_vf));
        n_b_num[2] = DEN_W'(9'd180 - 9'(w_hf));
        n_b_num[3] = DEN_W'(9'd180 + 9'(w_hf));
        n_b_num[4] = DEN_W'(DEN_W'(9'd180 - 9'(w_vf)) * DEN_W'(w_wd))
                   + DEN_W'(DEN_W'({w_vf, 1'b0}) * DEN_W'(col));
        n_b_num[5] = DEN_W'(DEN_W'(9'd180 - 9'(w_hf)) * DEN_W'(w_hd))
                   + DEN_W'(DEN_W'({w_hf, 1'b0}) * DEN_W'(row));
        n_b_den[0] = c360;
        n_b_den[1] = c360;
        n_b_den[2] = c360;
        n_b_den[3] = c360;
        n_b_den[4] = DEN_W'(c360 * DEN_W'(w_wd));
        n_b_den[5] = DEN_W'(c360 * DEN_W'(w_hd));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_num <= n_b_num;
            r_b_den <= n_b_den;
        end
    end

    // ---------------- stage C: pi * num, two partial products ----------------
    logic                            r_c_vld;
    logic [N_LANES-1:0][DEN_W+16:0]  r_c_plo, r_c_phi;
    logic [N_LANES-1:0][DEN_W-1:0]   r_c_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_LANES; k++) begin
                r_c_plo[k] <= (DEN_W+17)'((DEN_W+17)'(r_b_num[k]) * (DEN_W+17)'(PI_Q32_LO));
                r_c_phi[k] <= (DEN_W+17)'((DEN_W+17)'(r_b_num[k]) * (DEN_W+17)'(PI_Q32_HI));
            end
            r_c_den <= r_b_den;
        end
    end

    // ---------------- stage D: dividend with half-divisor rounding ----------------
    logic                         r_d_vld;
    logic [N_LANES-1:0][AD_W-1:0] r_d_rem, r_d_div;
    logic [N_LANES-1:0][QUO_W-1:0] r_d_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (w_en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [NW-1:0] n;
        if (w_en) begin
            for (int k = 0; k < N_LANES; k++) begin
                n = (NW'(r_c_phi[k]) << 17) + NW'(r_c_plo[k]) + (NW'(r_c_den[k]) << 15);
                r_d_rem[k] <= AD_W'(n >> QUO_W);
                r_d_low[k] <= n[QUO_W-1:0];
                r_d_div[k] <= AD_W'(r_c_den[k]) << 16;
            end
        end
    end

    // ---------------- angle division chain ----------------
    logic                          w_a_vld [QUO_W+1];
    logic [0:0]                    w_a_tag [QUO_W+1];
    logic [N_LANES-1:0][AD_W-1:0]  w_a_rem [QUO_W+1];
    logic [N_LANES-1:0][AD_W-1:0]  w_a_div [QUO_W+1];
    logic [N_LANES-1:0][QUO_W-1:0] w_a_low [QUO_W+1];
    logic [N_LANES-1:0][QUO_W-1:0] w_a_quo [QUO_W+1];

    assign w_a_vld[0] = r_d_vld;
    assign w_a_tag[0] = 1'b0;
    assign w_a_rem[0] = r_d_rem;
    assign w_a_div[0] = r_d_div;
    assign w_a_low[0] = r_d_low;
    assign w_a_quo[0] = '0;

    for (genvar g = 0; g < QUO_W; g++) begin : g_adiv
        frc_div_cell #(
            .L(N_LANES), .DW(AD_W), .LW(QUO_W), .QW(QUO_W), .TW(1)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(w_a_vld[g]), .i_tag(w_a_tag[g]), .i_rem(w_a_rem[g]),
            .i_low(w_a_low[g]), .i_quo(w_a_quo[g]), .i_div(w_a_div[g]),
            .o_vld(w_a_vld[g+1]), .o_tag(w_a_tag[g+1]), .o_rem(w_a_rem[g+1]),
            .o_low(w_a_low[g+1]), .o_quo(w_a_quo[g+1]), .o_div(w_a_div[g+1])
        );
    end

    // ---------------- CORDIC chain ----------------
    logic                          w_c_vld [TRIG_STAGES+1];
    logic [N_LANES-1:0][X_W-1:0]   w_c_x   [TRIG_STAGES+1];
    logic [N_LANES-1:0][X_W-1:0]   w_c_y   [TRIG_STAGES+1];
    logic [N_LANES-1:0][Z_W-1:0]   w_c_z   [TRIG_STAGES+1];

    assign w_c_vld[0] = w_a_vld[QUO_W];
    always_comb begin
        for (int k = 0; k < N_LANES; k++) begin
            w_c_x[0][k] = CORDIC_GAIN;
            w_c_y[0][k] = '0;
            w_c_z[0][k] = $signed({2'b00, w_a_quo[QUO_W][k]}) - HALF_PI_Q16;
        end
    end

    for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cordic
        frc_cordic_cell #(.STAGE(g), .L(N_LANES)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(w_c_vld[g]), .i_x(w_c_x[g]), .i_y(w_c_y[g]), .i_z(w_c_z[g]),
            .o_vld(w_c_vld[g+1]), .o_x(w_c_x[g+1]), .o_y(w_c_y[g+1]),
            .o_z(w_c_z[g+1])
        );
    end

    // ---------------- P1: sine / cosine clamp ----------------
    logic                         r_p1_vld;
    logic [N_LANES-1:0][SC_W-1:0] r_p1_s, r_p1_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= w_c_vld[TRIG_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_LANES; k++) begin
                r_p1_s[k] <= sat_unit((X_W+1)'($signed(w_c_x[TRIG_STAGES][k])));
                r_p1_c[k] <= sat_unit(-(X_W+1)'($signed(w_c_y[TRIG_STAGES][k])));
            end
        end
    end

    // ---------------- P2: product and scales ----------------
    logic                    r_p2_vld;
    logic signed [35:0]      r_p2_prod;
    logic signed [SC_W:0]    r_p2_xoff, r_p2_zscale, r_p2_zoff;
    logic signed [SC_W-1:0]  r_p2_ct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_vld <= 1'b0;
        end else if (w_en) begin
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [SC_W:0] xs, zs;
        if (w_en) begin
            xs = (SC_W+1)'($signed(r_p1_c[0])) - (SC_W+1)'($signed(r_p1_c[1]));
            zs = (SC_W+1)'($signed(r_p1_c[2])) - (SC_W+1)'($signed(r_p1_c[3]));
            r_p2_prod   <= $signed(r_p1_s[5]) * $signed(r_p1_c[4]);
            r_p2_xoff   <= xs >>> 1;
            r_p2_zscale <= zs;
            r_p2_zoff   <= zs >>> 1;
            r_p2_ct     <= $signed(r_p1_c[5]);
        end
    end

    // ---------------- P3: numerators against zscale ----------------
    logic                   r_p3_vld;
    logic [ZS_W-1:0]        r_p3_zs;
    logic signed [D_W-1:0]  r_p3_dx, r_p3_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_vld <= 1'b0;
        end else if (w_en) begin
            r_p3_vld <= r_p2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [D_W-1:0] xnum, znum, zsd;
        if (w_en) begin
            xnum = D_W'(r_p2_prod >>> 16) + D_W'(r_p2_xoff);
            znum = D_W'(r_p2_ct) + D_W'(r_p2_zoff);
            zsd  = (r_p2_zscale < 1) ? D_W'(1) : D_W'(r_p2_zscale);
            r_p3_zs <= ZS_W'(zsd);
            r_p3_dx <= zsd - xnum;
            r_p3_dy <= zsd - znum;
        end
    end

    // ---------------- P4: scale by source size, times 16 ----------------
    logic                   r_p4_vld;
    logic [ZS_W-1:0]        r_p4_zs;
    logic signed [PW-1:0]   r_p4_nx, r_p4_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_vld <= 1'b0;
        end else if (w_en) begin
            r_p4_vld <= r_p3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p4_zs <= r_p3_zs;
            r_p4_nx <= (PW'($signed({1'b0, w_ws})) * PW'(r_p3_dx)) <<< 4;
            r_p4_ny <= (PW'($signed({1'b0, w_hs})) * PW'(r_p3_dy)) <<< 4;
        end
    end

    // ---------------- P5: magnitude, rounding term, overflow ----------------
    logic                   r_p5_vld;
    logic [1:0][1:0]        r_p5_tag;   // per axis {negative, overflow}
    logic [1:0][ZS_W-1:0]   r_p5_rem, r_p5_div;
    logic [1:0][QUO_W-1:0]  r_p5_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_vld <= 1'b0;
        end else if (w_en) begin
            r_p5_vld <= r_p4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [PW-1:0] n;
        logic [PW-1:0]        mag;
        logic                 ovf;
        if (w_en) begin
            for (int a = 0; a < 2; a++) begin
                n   = (a == 0) ? r_p4_nx : r_p4_ny;
                mag = (n < 0) ? PW'(-n) : PW'(n);
                mag = mag + PW'(r_p4_zs >> 1);
                ovf = (mag >> QUO_W) >= PW'(r_p4_zs);
                r_p5_tag[a] <= {n < 0, ovf};
                r_p5_rem[a] <= ovf ? '0 : ZS_W'(mag >> QUO_W);
                r_p5_low[a] <= mag[QUO_W-1:0];
                r_p5_div[a] <= r_p4_zs;
            end
        end
    end

    // ---------------- map division chain (x and y lanes) ----------------
    logic                  w_m_vld [QUO_W+1];
    logic [3:0]            w_m_tag [QUO_W+1];
    logic [1:0][ZS_W-1:0]  w_m_rem [QUO_W+1];
    logic [1:0][ZS_W-1:0]  w_m_div [QUO_W+1];
    logic [1:0][QUO_W-1:0] w_m_low [QUO_W+1];
    logic [1:0][QUO_W-1:0] w_m_quo [QUO_W+1];

    assign w_m_vld[0] = r_p5_vld;
    assign w_m_tag[0] = r_p5_tag;
    assign w_m_rem[0] = r_p5_rem;
    assign w_m_div[0] = r_p5_div;
    assign w_m_low[0] = r_p5_low;
    assign w_m_quo[0] = '0;

    for (genvar g = 0; g < QUO_W; g++) begin : g_mdiv
        frc_div_cell #(
            .L(2), .DW(ZS_W), .LW(QUO_W), .QW(QUO_W), .TW(4)
        ) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(w_m_vld[g]), .i_tag(w_m_tag[g]), .i_rem(w_m_rem[g]),
            .i_low(w_m_low[g]), .i_quo(w_m_quo[g]), .i_div(w_m_div[g]),
            .o_vld(w_m_vld[g+1]), .o_tag(w_m_tag[g+1]), .o_rem(w_m_rem[g+1]),
            .o_low(w_m_low[g+1]), .o_quo(w_m_quo[g+1]), .o_div(w_m_div[g+1])
        );
    end

    // ---------------- output: sign, saturation, register ----------------
    logic [1:0][OUT_W-1:0] n_res;
    logic [1:0]            n_clip;

    always_comb begin
        logic [QUO_W-1:0] q;
        logic             neg, ovf;
        for (int a = 0; a < 2; a++) begin
            q   = w_m_quo[QUO_W][a];
            neg = w_m_tag[QUO_W][2*a+1];
            ovf = w_m_tag[QUO_W][2*a];
            if (neg) begin
                n_clip[a] = ovf || (q > QUO_W'(65536));
                n_res[a]  = n_clip[a] ? OUT_MIN : OUT_W'(-$signed({1'b0, q}));
            end else begin
                n_clip[a] = ovf || (q > QUO_W'(65535));
                n_res[a]  = n_clip[a] ? OUT_MAX : OUT_W'(q);
            end
        end
    end

    logic [OUT_W-1:0] r_out_x, r_out_y;
    logic             r_out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_m_vld[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x    <= n_res[0];
            r_out_y    <= n_res[1];
            r_out_clip <= |n_clip;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_out_clip, r_out_y, r_out_x};

    // ---------------- checks ----------------
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_clip_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out_clip) |->
            (r_out_x == OUT_MAX || r_out_x == OUT_MIN ||
             r_out_y == OUT_MAX || r_out_y == OUT_MIN))
        else $error("clipped flag without a saturated coordinate");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready not tied to output drain");

    a_angle_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_a_vld[QUO_W] |-> (w_a_tag[QUO_W] == 1'b0))
        else $error("angle chain sideband corrupted");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p5_vld && !w_en) |=> r_p5_vld)
        else $error("pipeline lost a request during a stall");

endmodule
